@@ rtl/tpld_pkg.sv @@
// ----------------------------------------------------------------------------
// tpld_pkg
// Shared types, constants and controller commands for the path length block.
// ----------------------------------------------------------------------------
package tpld_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned SqW = 66;
  localparam int unsigned LenW = 33;
  localparam int unsigned DivW = 63;
  localparam logic [31:0] TimeStepReset = 32'd16777;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] insertion_x;
    logic signed [31:0] insertion_y;
    logic signed [31:0] insertion_z;
    logic signed [31:0] via_x;
    logic signed [31:0] via_y;
    logic signed [31:0] via_z;
  } tpld_in_t;

  typedef struct packed {
    logic [31:0] path_length;
    logic signed [31:0] path_velocity;
    logic signed [31:0] origin_dir_x;
    logic signed [31:0] origin_dir_y;
    logic signed [31:0] origin_dir_z;
    logic signed [31:0] insertion_dir_x;
    logic signed [31:0] insertion_dir_y;
    logic signed [31:0] insertion_dir_z;
    logic signed [31:0] via_dir_x;
    logic signed [31:0] via_dir_y;
    logic signed [31:0] via_dir_z;
    logic degenerate;
  } tpld_out_t;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_SQ_START = 4'd2,
    OP_SQ_ACC = 4'd3,
    OP_SQRT_START = 4'd4,
    OP_SQRT_STEP = 4'd5,
    OP_SQRT_SAVE = 4'd6,
    OP_TOTAL = 4'd7,
    OP_DIV_START = 4'd8,
    OP_DIV_STEP = 4'd9,
    OP_DIV_SAVE = 4'd10,
    OP_FINISH = 4'd11
  } tpld_op_t;

  typedef struct packed {
    tpld_op_t op;
    logic [1:0] seg;
    logic [1:0] comp;
    logic [2:0] div_sel;
  } tpld_cmd_t;

  typedef struct packed {
    logic iter_done;
  } tpld_sts_t;

  localparam logic [2:0] DivVel = 3'd6;

endpackage

@@ rtl/three_point_path_length_direction.sv @@
// ----------------------------------------------------------------------------
// three_point_path_length_direction
// Path length, velocity and unit direction vectors of a three-point strap.
// ----------------------------------------------------------------------------
// Each length is the bit-serial square root of the summed squares of its components,
// found after a setup step. Seven divisions share one restoring divider.
// One transaction is in flight at a time; a new input is taken only once the
// previous result has been accepted.
// Reset sets time_step to 16777 and the previous length to zero.
module three_point_path_length_direction (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tpld_pkg::tpld_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpld_pkg::tpld_out_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [31:0] time_step_r;
  tpld_pkg::tpld_cmd_t cmd;
  tpld_pkg::tpld_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? time_step_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= tpld_pkg::TimeStepReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      time_step_r <= cfg_pwdata;
    end
  end

  tpld_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  tpld_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .time_step(time_step_r),
    .cmd(cmd), .sts(sts), .result(out_data)
  );

endmodule

@@ rtl/tpld_datapath.sv @@
// ----------------------------------------------------------------------------
// tpld_datapath
// Operand registers, a shared square unit, a bit-serial root and divider.
// ----------------------------------------------------------------------------
module tpld_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tpld_pkg::tpld_in_t   in_data,
  input  logic [31:0]          time_step,
  input  tpld_pkg::tpld_cmd_t  cmd,
  output tpld_pkg::tpld_sts_t  sts,
  output tpld_pkg::tpld_out_t  result
);

  logic signed [32:0] d_r [6];
  logic [65:0] sq_acc_r;
  logic [32:0] root_r, root_nxt;
  logic [5:0] iter_r, iter_nxt;
  logic [32:0] len_r [2];
  logic [31:0] total_r, prev_r, prev_nxt;
  logic diff_neg_r;
  logic [62:0] num_r;
  logic [56:0] rem_r;
  logic [32:0] den_r;
  logic [31:0] quo_r [6];
  logic signed [31:0] vel_r;
  logic [65:0] sq_r;
  logic [32:0] sq_mag;
  logic [2:0] di;
  logic [65:0] trial_sq;
  logic [32:0] cand;
  logic [57:0] rem_sh;
  logic [56:0] rem_next;
  logic signed [32:0] dsel;
  logic [32:0] dmag;
  logic [33:0] tot_sum;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic [31:0] dq [6];
  logic signed [33:0] vsum [3];
  logic [32:0] qv;
  logic signed [31:0] vel_nxt;

  assign di = {1'b0, cmd.seg} * 3'd3 + {1'b0, cmd.comp};
  assign sq_mag = d_r[di][32] ? 33'(-d_r[di]) : 33'(d_r[di]);
  assign cand = root_r | (33'd1 << iter_r);
  assign trial_sq = 66'(cand) * 66'(cand);
  assign rem_sh = {rem_r, num_r[62]};
  assign rem_next = (rem_sh >= 58'(den_r)) ? 57'(rem_sh - 58'(den_r)) : rem_sh[56:0];
  assign dsel = d_r[cmd.div_sel];
  assign dmag = dsel[32] ? 33'(-dsel) : 33'(dsel);
  assign tot_sum = 34'(len_r[0]) + 34'(len_r[1]);
  assign diff = $signed({1'b0, total_r}) - $signed({1'b0, prev_r});
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign sts.iter_done = (iter_r == 6'd0);

  always_comb begin
    root_nxt = root_r;
    iter_nxt = iter_r;
    unique case (cmd.op)
      tpld_pkg::OP_SQRT_START: begin
        root_nxt = '0;
        iter_nxt = 6'd32;
      end
      tpld_pkg::OP_SQRT_STEP: begin
        if (trial_sq <= sq_acc_r) begin
          root_nxt = cand;
        end
        if (iter_r != 6'd0) begin
          iter_nxt = iter_r - 6'd1;
        end
      end
      tpld_pkg::OP_DIV_START: begin
        iter_nxt = 6'd62;
      end
      tpld_pkg::OP_DIV_STEP: begin
        if (iter_r != 6'd0) begin
          iter_nxt = iter_r - 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      iter_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      iter_r <= iter_nxt;
    end
    root_r <= root_nxt;
    unique case (cmd.op)
      tpld_pkg::OP_LOAD: begin
        d_r[0] <= 33'(in_data.via_x) - 33'(in_data.origin_x);
        d_r[1] <= 33'(in_data.via_y) - 33'(in_data.origin_y);
        d_r[2] <= 33'(in_data.via_z) - 33'(in_data.origin_z);
        d_r[3] <= 33'(in_data.via_x) - 33'(in_data.insertion_x);
        d_r[4] <= 33'(in_data.via_y) - 33'(in_data.insertion_y);
        d_r[5] <= 33'(in_data.via_z) - 33'(in_data.insertion_z);
      end
      tpld_pkg::OP_SQ_START: begin
        sq_acc_r <= '0;
        sq_r <= 66'(sq_mag) * 66'(sq_mag);
      end
      tpld_pkg::OP_SQ_ACC: begin
        sq_acc_r <= sq_acc_r + sq_r;
        sq_r <= 66'(sq_mag) * 66'(sq_mag);
      end
      tpld_pkg::OP_SQRT_SAVE: begin
        len_r[cmd.seg[0]] <= root_r;
      end
      tpld_pkg::OP_TOTAL: begin
        total_r <= (tot_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : tot_sum[31:0];
      end
      tpld_pkg::OP_DIV_START: begin
        rem_r <= '0;
        if (cmd.div_sel == tpld_pkg::DivVel) begin
          num_r <= {6'd0, diff_mag, 24'd0};
          den_r <= {1'b0, time_step};
          diff_neg_r <= diff[32];
        end else begin
          num_r <= {dmag, 30'd0};
          den_r <= len_r[cmd.div_sel >= 3'd3];
          diff_neg_r <= dsel[32];
        end
      end
      tpld_pkg::OP_DIV_STEP: begin
        rem_r <= rem_next;
        num_r <= {num_r[61:0], (rem_sh >= 58'(den_r))};
      end
      tpld_pkg::OP_DIV_SAVE: begin
        if (cmd.div_sel == tpld_pkg::DivVel) begin
          vel_r <= vel_nxt;
        end else begin
          quo_r[cmd.div_sel] <= (den_r == '0) ? 32'd0 :
            (diff_neg_r ? 32'(-num_r[31:0]) : num_r[31:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // The quotient bits shift into num_r from the bottom while the dividend leaves at the top.
  always_comb begin
    qv = (num_r > 63'h0_8000_0000) ? 33'h0_8000_0000 : num_r[32:0];
    if (time_step == '0) begin
      vel_nxt = '0;
    end else if (diff_neg_r) begin
      vel_nxt = 32'(-qv);
    end else if (qv[31]) begin
      vel_nxt = 32'h7FFF_FFFF;
    end else begin
      vel_nxt = qv[31:0];
    end
  end

  assign prev_nxt = (cmd.op == tpld_pkg::OP_FINISH) ? total_r : prev_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dq[i] = quo_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      vsum[i] = -(34'($signed(dq[i])) + 34'($signed(dq[i + 3])));
    end
  end

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign result.path_length = total_r;
  assign result.path_velocity = vel_r;
  assign result.origin_dir_x = dq[0];
  assign result.origin_dir_y = dq[1];
  assign result.origin_dir_z = dq[2];
  assign result.insertion_dir_x = dq[3];
  assign result.insertion_dir_y = dq[4];
  assign result.insertion_dir_z = dq[5];
  assign result.via_dir_x = sat34(vsum[0]);
  assign result.via_dir_y = sat34(vsum[1]);
  assign result.via_dir_z = sat34(vsum[2]);
  assign result.degenerate = (len_r[0] == '0) || (len_r[1] == '0);

endmodule

@@ rtl/tpld_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpld_ctrl
// Sequencer that steps the datapath through load, squares, roots, total and divisions.
// ----------------------------------------------------------------------------
module tpld_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tpld_pkg::tpld_sts_t  sts,
  output tpld_pkg::tpld_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_SQRT0 = 9'b000000100,
    S_SQRT  = 9'b000001000,
    S_TOTAL = 9'b000010000,
    S_DIV0  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [2:0] dsel_r, dsel_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    seg_nxt = seg_r;
    comp_nxt = comp_r;
    dsel_nxt = dsel_r;
    cmd = '{op: tpld_pkg::OP_NONE, seg: seg_r, comp: comp_r, div_sel: dsel_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = tpld_pkg::OP_LOAD;
          seg_nxt = 2'd0;
          comp_nxt = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = (comp_r == 2'd0) ? tpld_pkg::OP_SQ_START : tpld_pkg::OP_SQ_ACC;
        if (comp_r == 2'd3) begin
          state_nxt = S_SQRT0;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      S_SQRT0: begin
        cmd.op = tpld_pkg::OP_SQRT_START;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sts.iter_done && comp_r == 2'd0) begin
          cmd.op = tpld_pkg::OP_SQRT_SAVE;
          if (seg_r == 2'd1) begin
            state_nxt = S_TOTAL;
          end else begin
            seg_nxt = 2'd1;
            state_nxt = S_SQ;
          end
        end else begin
          cmd.op = tpld_pkg::OP_SQRT_STEP;
          if (sts.iter_done) begin
            comp_nxt = 2'd0;
          end
        end
      end
      S_TOTAL: begin
        cmd.op = tpld_pkg::OP_TOTAL;
        dsel_nxt = 3'd0;
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        cmd.op = tpld_pkg::OP_DIV_START;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = tpld_pkg::OP_DIV_STEP;
        if (sts.iter_done) begin
          comp_nxt = 2'd1;
        end
        if (comp_r == 2'd1) begin
          cmd.op = tpld_pkg::OP_DIV_SAVE;
          comp_nxt = 2'd0;
          if (dsel_r == tpld_pkg::DivVel) begin
            state_nxt = S_FIN;
          end else begin
            dsel_nxt = dsel_r + 3'd1;
            state_nxt = S_DIV0;
          end
        end
      end
      S_FIN: begin
        cmd.op = tpld_pkg::OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_r <= '0;
      comp_r <= '0;
      dsel_r <= '0;
    end else begin
      state_r <= state_nxt;
      seg_r <= seg_nxt;
      comp_r <= comp_nxt;
      dsel_r <= dsel_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

endmodule

@@ tb/sv/tpld_checker.sv @@
// ----------------------------------------------------------------------------
// tpld_checker
// Watches both channels and the register port of the path length block,
// predicts each result from the accepted input and compares field by field.
// ----------------------------------------------------------------------------
module tpld_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tpld_pkg::tpld_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tpld_pkg::tpld_out_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] AddrTimeStep = 2'd0;

  logic [31:0] step_reg;
  logic [31:0] last_length;
  tpld_pkg::tpld_out_t expected_q[$];

  function automatic logic [32:0] isqrt66(logic [65:0] s);
    logic [32:0] r;
    logic [32:0] c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if ({33'd0, c} * {33'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [32:0] seg_len(logic signed [32:0] d[3]);
    logic [65:0] acc;
    logic [32:0] m;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      m = d[i][32] ? -d[i] : d[i];
      acc += {33'd0, m} * {33'd0, m};
    end
    return isqrt66(acc);
  endfunction

  function automatic logic signed [63:0] unit(logic signed [32:0] d, logic [32:0] len);
    logic [63:0] m;
    logic [63:0] q;
    if (len == 0) return 0;
    m = d[32] ? 64'(-d) : 64'(d);
    q = (m << 30) / 64'(len);
    return d[32] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic tpld_pkg::tpld_out_t predict_path(tpld_pkg::tpld_in_t p);
    logic signed [32:0] d1[3];
    logic signed [32:0] d2[3];
    logic signed [31:0] org[3];
    logic signed [31:0] ins[3];
    logic signed [31:0] via[3];
    logic [32:0] l1;
    logic [32:0] l2;
    logic [33:0] sum;
    logic [31:0] total;
    logic signed [63:0] diff;
    logic [63:0] m;
    logic [63:0] q;
    logic signed [63:0] o[3];
    logic signed [63:0] n[3];
    tpld_pkg::tpld_out_t r;
    org = '{p.origin_x, p.origin_y, p.origin_z};
    ins = '{p.insertion_x, p.insertion_y, p.insertion_z};
    via = '{p.via_x, p.via_y, p.via_z};
    for (int i = 0; i < 3; i++) begin
      d1[i] = 33'(via[i]) - 33'(org[i]);
      d2[i] = 33'(via[i]) - 33'(ins[i]);
    end
    l1 = seg_len(d1);
    l2 = seg_len(d2);
    sum = 34'(l1) + 34'(l2);
    total = (sum > 34'hffffffff) ? 32'hffffffff : sum[31:0];
    r.path_velocity = '0;
    if (step_reg != 0) begin
      diff = $signed({32'd0, total}) - $signed({32'd0, last_length});
      m = diff < 0 ? -diff : diff;
      q = (m << 24) / {32'd0, step_reg};
      if (q > 64'h80000000) q = 64'h80000000;
      r.path_velocity = clip32(diff < 0 ? -$signed(q) : $signed(q));
    end
    last_length = total;
    for (int i = 0; i < 3; i++) begin
      o[i] = unit(d1[i], l1);
      n[i] = unit(d2[i], l2);
    end
    r.path_length = total;
    r.origin_dir_x = o[0][31:0];
    r.origin_dir_y = o[1][31:0];
    r.origin_dir_z = o[2][31:0];
    r.insertion_dir_x = n[0][31:0];
    r.insertion_dir_y = n[1][31:0];
    r.insertion_dir_z = n[2][31:0];
    r.via_dir_x = clip32(-(o[0] + n[0]));
    r.via_dir_y = clip32(-(o[1] + n[1]));
    r.via_dir_z = clip32(-(o[2] + n[2]));
    r.degenerate = (l1 == 0) || (l2 == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tpld_pkg::tpld_out_t e;
    if (!rst_n) begin
      step_reg = tpld_pkg::TimeStepReset;
      last_length = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == AddrTimeStep)
        step_reg = cfg_pwdata;
      if (in_valid && in_ready) expected_q = {expected_q, predict_path(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("Result transaction with no prediction waiting.");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("path_length", e.path_length, out_data.path_length);
          compare_field("path_velocity", e.path_velocity, out_data.path_velocity);
          compare_field("origin_dir_x", e.origin_dir_x, out_data.origin_dir_x);
          compare_field("origin_dir_y", e.origin_dir_y, out_data.origin_dir_y);
          compare_field("origin_dir_z", e.origin_dir_z, out_data.origin_dir_z);
          compare_field("insertion_dir_x", e.insertion_dir_x, out_data.insertion_dir_x);
          compare_field("insertion_dir_y", e.insertion_dir_y, out_data.insertion_dir_y);
          compare_field("insertion_dir_z", e.insertion_dir_z, out_data.insertion_dir_z);
          compare_field("via_dir_x", e.via_dir_x, out_data.via_dir_x);
          compare_field("via_dir_y", e.via_dir_y, out_data.via_dir_y);
          compare_field("via_dir_z", e.via_dir_z, out_data.via_dir_z);
          compare_field("degenerate", 32'(e.degenerate), 32'(out_data.degenerate));
        end
      end
    end
  end

  assign pending_count = expected_q.size();
endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives random and corner-case strap geometry into the path length block
// under several time steps and handshake pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] AddrTimeStep = 2'd0;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tpld_pkg::tpld_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpld_pkg::tpld_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  three_point_path_length_direction dut (.*);

  tpld_checker checker_i (.*);

  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_step(logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AddrTimeStep;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic send_point(tpld_pkg::tpld_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 65535 * 8))) - 32'sd262144;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed(32'($urandom_range(0, 2047))) - 32'sd1024;
    endcase
  endfunction

  function automatic tpld_pkg::tpld_in_t random_point();
    tpld_pkg::tpld_in_t p;
    int mode;
    mode = $urandom_range(3);
    p.origin_x = rand_coord(mode);
    p.origin_y = rand_coord(mode);
    p.origin_z = rand_coord(mode);
    p.insertion_x = rand_coord(mode);
    p.insertion_y = rand_coord(mode);
    p.insertion_z = rand_coord(mode);
    p.via_x = rand_coord(mode);
    p.via_y = rand_coord(mode);
    p.via_z = rand_coord(mode);
    case ($urandom_range(15))
      0: {p.origin_x, p.origin_y, p.origin_z} = {p.via_x, p.via_y, p.via_z};
      1: {p.insertion_x, p.insertion_y, p.insertion_z} = {p.via_x, p.via_y, p.via_z};
      2: begin
        p.insertion_x = 32'(-p.origin_x + 2 * p.via_x);
        p.insertion_y = p.origin_y;
        p.insertion_z = p.origin_z;
        p.via_y = p.origin_y;
        p.via_z = p.origin_z;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_directed;
    tpld_pkg::tpld_in_t p;
    p = '0;
    send_point(p);
    p.via_x = 32'h00010000;
    send_point(p);
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_point(p);
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000};
    send_point(p);
    p = '{32'hffff0000, 0, 0, 32'h00010000, 0, 0, 0, 0, 0};
    send_point(p);
    p = '{0, 32'h00030000, 0, 0, 0, 32'h00040000, 0, 0, 0};
    send_point(p);
    p = '{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 32'h7fffffff, 0};
    send_point(p);
    p = '{1, 1, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0};
    send_point(p);
    p = '0;
    send_point(p);
    for (int i = 0; i < 8; i++) send_point(random_point());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_directed();
    drain();
    write_step(32'd0);
    send_directed();
    drain();
    write_step(32'hffffffff);
    send_directed();
    drain();
    write_step(32'd1);
    send_idle_pct = 18;
    recv_idle_pct = 62;
    for (int i = 0; i < 600; i++) send_point(random_point());
    drain();
    write_step(32'd16777);
    send_idle_pct = 62;
    recv_idle_pct = 18;
    for (int i = 0; i < 600; i++) send_point(random_point());
    drain();
    write_step($urandom());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_point(random_point());
    join
    for (int i = 0; i < 640; i++) send_point(random_point());
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
